### sv/tcl_pkg.sv
// Shared types and constants of the tile cache.
package tcl_pkg;

  localparam int CAPACITY  = 64;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ZOOM_W    = 5;
  localparam int COORD_W   = 20;
  localparam int KEY_W     = ZOOM_W + 2 * COORD_W;
  localparam int STAMP_W   = 32;
  localparam int HANDLE_W  = 32;

  localparam logic FUNC_LOOKUP = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [STAMP_W-1:0]  stamp;
    logic [HANDLE_W-1:0] handle;
    logic                owned;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } ram_req_t;

endpackage

### sv/tcl_entry_ram.sv
// Entry store of the tile cache: one write port, one registered read port.
module tcl_entry_ram (
  input  logic              clk_i,
  input  tcl_pkg::ram_req_t req_i,
  output tcl_pkg::entry_t   rd_data_o
);

  tcl_pkg::entry_t mem [tcl_pkg::CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem[req_i.rd_addr];
    end
  end

endmodule

### sv/tile_cache_lru.sv
// Top level of the fully associative LRU tile cache.
// A lookup, or an insert into a cache that is not full, makes one scan of the
// entry RAM; an insert into a full cache makes a victim scan, then a key scan.
// The cache takes one item at a time: a new request is accepted only in the idle
// state, and the single read port of the entry RAM serializes the scans.
// Reset: rst_ni clears valid bits, fill count, use counter and all handshake state;
// the entry RAM is not cleared, since invalid entries are never used.
module tile_cache_lru (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [tcl_pkg::ZOOM_W-1:0]     tile_zoom_i,
  input  logic [tcl_pkg::COORD_W-1:0]    tile_col_i,
  input  logic [tcl_pkg::COORD_W-1:0]    tile_row_i,
  input  logic [tcl_pkg::HANDLE_W-1:0]   buffer_handle_i,
  input  logic                           owned_flag_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           hit_o,
  output logic [tcl_pkg::HANDLE_W-1:0]   found_handle_o,
  output logic                           evicted_o,
  output logic [tcl_pkg::HANDLE_W-1:0]   evicted_handle_o,
  output logic                           evicted_owned_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VSCAN,   // search the least recently used entry
    ST_FSCAN,   // search the key and the lowest free slot
    ST_DONE     // hand the result to the output register
  } state_e;

  state_e state_q;

  // Captured request.
  logic                          func_q;
  logic [tcl_pkg::KEY_W-1:0]     key_q;
  logic [tcl_pkg::HANDLE_W-1:0]  handle_q;
  logic                          owned_q;

  // Cache bookkeeping.
  logic [tcl_pkg::CAPACITY-1:0]  valid_q;
  logic [tcl_pkg::CNT_W-1:0]     fill_q;
  logic [tcl_pkg::STAMP_W-1:0]   cnt_q;

  // Scan pipeline: address issued now, data compared in the next cycle.
  logic [tcl_pkg::CNT_W-1:0]     scan_idx_q;
  logic                          pend_q;
  logic [tcl_pkg::IDX_W-1:0]     pend_idx_q;

  // Victim search results.
  logic                          best_vld_q;
  logic [tcl_pkg::IDX_W-1:0]     best_idx_q;
  logic [tcl_pkg::STAMP_W-1:0]   best_stamp_q;
  logic [tcl_pkg::KEY_W-1:0]     best_key_q;
  logic [tcl_pkg::HANDLE_W-1:0]  best_handle_q;
  logic                          best_owned_q;

  // Key search results.
  logic                          found_q;
  logic [tcl_pkg::IDX_W-1:0]     found_idx_q;
  logic [tcl_pkg::HANDLE_W-1:0]  found_handle_q;
  logic                          found_owned_q;
  logic                          free_vld_q;
  logic [tcl_pkg::IDX_W-1:0]     free_idx_q;

  // Result waiting for the output register.
  logic                          res_hit_q;
  logic [tcl_pkg::HANDLE_W-1:0]  res_found_q;
  logic                          res_ev_q;
  logic [tcl_pkg::HANDLE_W-1:0]  res_evh_q;
  logic                          res_evo_q;

  tcl_pkg::ram_req_t             ram_req;
  tcl_pkg::entry_t               rd_data;

  logic                          in_xfer;
  logic                          scan_issue;
  logic                          scan_end;
  logic                          pend_valid;
  logic                          key_match;
  logic                          victim_better;
  logic                          out_free;
  logic [tcl_pkg::STAMP_W-1:0]   cnt_inc;
  logic [tcl_pkg::IDX_W-1:0]     ins_idx;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign cnt_inc    = cnt_q + tcl_pkg::STAMP_W'(1);

  assign scan_issue = ((state_q == ST_VSCAN) || (state_q == ST_FSCAN)) &&
                      (scan_idx_q != tcl_pkg::CNT_W'(tcl_pkg::CAPACITY));
  assign scan_end   = (scan_idx_q == tcl_pkg::CNT_W'(tcl_pkg::CAPACITY)) && !pend_q;

  assign pend_valid = valid_q[pend_idx_q];
  assign key_match  = pend_valid && (rd_data.key == key_q);

  // Smaller stamp wins; equal stamps (after wrap) go to the smaller key.
  assign victim_better = !best_vld_q || (rd_data.stamp < best_stamp_q) ||
                         ((rd_data.stamp == best_stamp_q) && (rd_data.key < best_key_q));

  // A present key is overwritten in place, a new one takes the lowest free slot.
  assign ins_idx = found_q ? found_idx_q : free_idx_q;

  always_comb begin
    ram_req         = '0;
    ram_req.rd_en   = scan_issue;
    ram_req.rd_addr = scan_idx_q[tcl_pkg::IDX_W-1:0];
    if ((state_q == ST_FSCAN) && scan_end) begin
      if (func_q == tcl_pkg::FUNC_INSERT) begin
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = ins_idx;
        ram_req.wr_data = '{key: key_q, stamp: cnt_inc, handle: handle_q, owned: owned_q};
      end else if (found_q) begin
        // Restamp the hit entry; rewrite the rest as it was.
        ram_req.wr_en   = 1'b1;
        ram_req.wr_addr = found_idx_q;
        ram_req.wr_data = '{key: key_q, stamp: cnt_inc, handle: found_handle_q,
                            owned: found_owned_q};
      end
    end
  end

  tcl_entry_ram u_ram (
    .clk_i     (clk_i),
    .req_i     (ram_req),
    .rd_data_o (rd_data)
  );

  // Control state and the output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      fill_q      <= '0;
      cnt_q       <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      best_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      free_vld_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      // Raise valid when a result moves into the output register, drop it once transferred.
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end

      // Advance the scan pipeline.
      pend_q <= scan_issue;
      if (scan_issue) begin
        scan_idx_q <= scan_idx_q + tcl_pkg::CNT_W'(1);
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            scan_idx_q <= '0;
            best_vld_q <= 1'b0;
            found_q    <= 1'b0;
            free_vld_q <= 1'b0;
            if ((func_i == tcl_pkg::FUNC_INSERT) &&
                (fill_q >= tcl_pkg::CNT_W'(tcl_pkg::CAPACITY))) begin
              state_q <= ST_VSCAN;
            end else begin
              state_q <= ST_FSCAN;
            end
          end
        end

        ST_VSCAN: begin
          if (pend_q && pend_valid && victim_better) begin
            best_vld_q <= 1'b1;
          end
          if (scan_end) begin
            // Drop the victim, then look for the key among the rest.
            if (best_vld_q) begin
              valid_q[best_idx_q] <= 1'b0;
              fill_q              <= fill_q - tcl_pkg::CNT_W'(1);
            end
            scan_idx_q <= '0;
            state_q    <= ST_FSCAN;
          end
        end

        ST_FSCAN: begin
          if (pend_q && key_match && !found_q) begin
            found_q <= 1'b1;
          end
          if (pend_q && !pend_valid && !free_vld_q) begin
            free_vld_q <= 1'b1;
          end
          if (scan_end) begin
            if (func_q == tcl_pkg::FUNC_INSERT) begin
              cnt_q <= cnt_inc;
              if (!found_q) begin
                valid_q[free_idx_q] <= 1'b1;
                fill_q              <= fill_q + tcl_pkg::CNT_W'(1);
              end
            end else if (found_q) begin
              cnt_q <= cnt_inc;
            end
            state_q <= ST_DONE;
          end
        end

        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers: request capture, search results, result fields.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q    <= func_i;
      key_q     <= {tile_zoom_i, tile_col_i, tile_row_i};
      handle_q  <= buffer_handle_i;
      owned_q   <= owned_flag_i;
      res_hit_q   <= 1'b0;
      res_found_q <= '0;
      res_ev_q    <= 1'b0;
      res_evh_q   <= '0;
      res_evo_q   <= 1'b0;
    end

    if ((state_q == ST_VSCAN) && pend_q && pend_valid && victim_better) begin
      best_idx_q    <= pend_idx_q;
      best_stamp_q  <= rd_data.stamp;
      best_key_q    <= rd_data.key;
      best_handle_q <= rd_data.handle;
      best_owned_q  <= rd_data.owned;
    end

    if ((state_q == ST_VSCAN) && scan_end && best_vld_q) begin
      res_ev_q  <= 1'b1;
      res_evh_q <= best_handle_q;
      res_evo_q <= best_owned_q;
    end

    if ((state_q == ST_FSCAN) && pend_q && key_match && !found_q) begin
      found_idx_q    <= pend_idx_q;
      found_handle_q <= rd_data.handle;
      found_owned_q  <= rd_data.owned;
    end
    if ((state_q == ST_FSCAN) && pend_q && !pend_valid && !free_vld_q) begin
      free_idx_q <= pend_idx_q;
    end

    if ((state_q == ST_FSCAN) && scan_end && (func_q == tcl_pkg::FUNC_LOOKUP) && found_q) begin
      res_hit_q   <= 1'b1;
      res_found_q <= found_handle_q;
    end

    if (scan_issue) begin
      pend_idx_q <= scan_idx_q[tcl_pkg::IDX_W-1:0];
    end

    if ((state_q == ST_DONE) && out_free) begin
      hit_o            <= res_hit_q;
      found_handle_o   <= res_found_q;
      evicted_o        <= res_ev_q;
      evicted_handle_o <= res_evh_q;
      evicted_owned_o  <= res_evo_q;
    end
  end

endmodule

### sv/tcl_checker.sv
// Port-level checks of the tile cache and their binding to the top level.
module tcl_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic                         hit_o,
  input logic [tcl_pkg::HANDLE_W-1:0] found_handle_o,
  input logic                         evicted_o,
  input logic [tcl_pkg::HANDLE_W-1:0] evicted_handle_o,
  input logic                         evicted_owned_o
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(found_handle_o) && $stable(evicted_handle_o) &&
      $stable(hit_o) && $stable(evicted_o) && $stable(evicted_owned_o))
    else $error("stalled result changed");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(hit_o && evicted_o))
    else $error("lookup hit and eviction in one result");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> found_handle_o == '0)
    else $error("found handle nonzero without hit");

  a_no_evict_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !evicted_o |-> (evicted_handle_o == '0) && !evicted_owned_o)
    else $error("eviction fields nonzero without eviction");

endmodule

bind tile_cache_lru tcl_checker u_tcl_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .hit_o            (hit_o),
  .found_handle_o   (found_handle_o),
  .evicted_o        (evicted_o),
  .evicted_handle_o (evicted_handle_o),
  .evicted_owned_o  (evicted_owned_o)
);
